// ===== sv/mlpq_pkg.sv =====
// Shared constants and types for the multilevel priority queue.
package mlpq_pkg;

    // Queue geometry
    localparam int MAX_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int PAYLOAD_W   = 32;
    localparam int PRIO_W      = 4;

    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W = LVL_W + PTR_W;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Level count after reset
    localparam logic [PRIO_W-1:0] LEVELS_RESET = PRIO_W'(MAX_LEVELS);

    // Storage access issued by the control stage
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PAYLOAD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Registered result of one item
    typedef struct packed {
        logic              accepted;
        logic              all_empty;
        logic [PRIO_W-1:0] level;
        logic              bypass;
        logic [PAYLOAD_W-1:0] pay;
    } t_result;

endpackage

// ===== sv/mlpq_mem.sv =====
// Payload storage: one write port and one registered read port.
module mlpq_mem
    import mlpq_pkg::*;
(
    input  logic                 i_clk,
    input  t_mem_req             i_req,
    output logic [PAYLOAD_W-1:0] o_rd_data
);

    logic [PAYLOAD_W-1:0] r_store [MAX_LEVELS*LEVEL_DEPTH];
    logic [PAYLOAD_W-1:0] r_rd_data;

    // Write at the tail, read the new front head (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_store[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_store[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/mlpq_ctrl.sv =====
// Input register, per-level pointers and counts, front selection and result register.
module mlpq_ctrl
    import mlpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [PRIO_W-1:0]    i_cfg_data,
    input  logic                 i_accept,
    input  logic                 i_op,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic [PAYLOAD_W-1:0] i_payload,
    output t_mem_req             o_mem_req,
    output logic                 o_res_vld,
    output t_result              o_res
);

    // Configuration and input register
    logic [PRIO_W-1:0]    r_lvls;
    logic                 r_in_vld;
    logic                 r_op;
    logic [PRIO_W-1:0]    r_prio;
    logic [PAYLOAD_W-1:0] r_pay;

    // Per-level FIFO state
    logic [PTR_W-1:0] r_head  [MAX_LEVELS];
    logic [PTR_W-1:0] r_tail  [MAX_LEVELS];
    logic [CNT_W-1:0] r_count [MAX_LEVELS];
    logic [PTR_W-1:0] n_head  [MAX_LEVELS];
    logic [PTR_W-1:0] n_tail  [MAX_LEVELS];
    logic [CNT_W-1:0] n_count [MAX_LEVELS];

    // Result register
    logic    r_res_vld;
    t_result r_res;
    t_result n_res;

    logic [PRIO_W-1:0]     n_lvls;
    logic [MAX_LEVELS-1:0] en_mask;
    logic [MAX_LEVELS-1:0] cur_ne;
    logic [MAX_LEVELS-1:0] nxt_ne;
    logic                  cur_found;
    logic [LVL_W-1:0]      cur_idx;
    logic                  nxt_found;
    logic [LVL_W-1:0]      nxt_idx;
    logic                  enq_ok;
    logic [LVL_W-1:0]      enq_lvl;
    logic                  do_enq;
    logic                  do_deq;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Lowest set bit: highest-priority non-empty level
    function automatic logic [LVL_W:0] first_set(input logic [MAX_LEVELS-1:0] v);
        logic [LVL_W:0] res;
        res = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, LVL_W'(i)};
            end
        end
        return res;
    endfunction

    // Clamp the enabled level count to 1..MAX_LEVELS
    always_comb begin
        if (r_lvls == '0) begin
            n_lvls = PRIO_W'(1);
        end else if (r_lvls > PRIO_W'(MAX_LEVELS)) begin
            n_lvls = PRIO_W'(MAX_LEVELS);
        end else begin
            n_lvls = r_lvls;
        end
        for (int i = 0; i < MAX_LEVELS; i++) begin
            en_mask[i] = (PRIO_W'(i) < n_lvls);
            cur_ne[i]  = (r_count[i] != '0) && en_mask[i];
        end
        {cur_found, cur_idx} = first_set(cur_ne);
    end

    // Operation decode
    always_comb begin
        enq_ok  = (r_prio != '0) && (r_prio <= n_lvls);
        enq_lvl = LVL_W'(r_prio - PRIO_W'(1));
        do_enq  = r_in_vld && (r_op == OP_ENQ) && enq_ok
                  && (r_count[enq_lvl] != CNT_W'(LEVEL_DEPTH));
        do_deq  = r_in_vld && (r_op == OP_DEQ) && cur_found;
    end

    // Pointer and count update
    always_comb begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            n_head[i]  = r_head[i];
            n_tail[i]  = r_tail[i];
            n_count[i] = r_count[i];
        end
        if (do_enq) begin
            n_tail[enq_lvl]  = advance(r_tail[enq_lvl]);
            n_count[enq_lvl] = r_count[enq_lvl] + CNT_W'(1);
        end
        if (do_deq) begin
            n_head[cur_idx]  = advance(r_head[cur_idx]);
            n_count[cur_idx] = r_count[cur_idx] - CNT_W'(1);
        end
        for (int i = 0; i < MAX_LEVELS; i++) begin
            nxt_ne[i] = (n_count[i] != '0) && en_mask[i];
        end
        {nxt_found, nxt_idx} = first_set(nxt_ne);
    end

    // Storage request and next result
    always_comb begin
        waddr = {enq_lvl, r_tail[enq_lvl]};
        raddr = {nxt_idx, n_head[nxt_idx]};

        o_mem_req.we    = do_enq;
        o_mem_req.waddr = waddr;
        o_mem_req.wdata = r_pay;
        o_mem_req.raddr = raddr;

        n_res.accepted  = do_enq || do_deq;
        n_res.all_empty = !nxt_found;
        n_res.level     = nxt_found ? PRIO_W'(nxt_idx) + PRIO_W'(1) : '0;
        n_res.bypass    = do_enq && (waddr == raddr);
        n_res.pay       = r_pay;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvls    <= LEVELS_RESET;
            r_in_vld  <= 1'b0;
            r_res_vld <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_lvls <= i_cfg_data;
            end
            r_in_vld  <= i_accept;
            r_res_vld <= r_in_vld;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i]  <= n_head[i];
                r_tail[i]  <= n_tail[i];
                r_count[i] <= n_count[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op   <= i_op;
            r_prio <= i_priority_req;
            r_pay  <= i_payload;
        end
        r_res <= n_res;
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

endmodule

// ===== sv/multilevel_priority_fifo.sv =====
// Top level of the strict-priority multilevel queue.
// One item (enqueue or dequeue) is taken every cycle; busy never rises. Each
// item gives one result on o_done: the edge that samples start loads the
// input register, and after it the pointer update, the result and the payload
// store read are registered. The result is shown for one cycle only and cannot
// be stalled, so the receiver must take it when o_done is high. levels_in_use
// (i_cfg_data, reset 8) is written with i_cfg_we; the user must write it only
// while no item is in flight, as the block itself does not enforce this.
module multilevel_priority_fifo
    import mlpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [PRIO_W-1:0]    i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_op,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic [PAYLOAD_W-1:0] i_payload,
    output logic                 o_done,
    output logic                 o_accepted,
    output logic                 o_all_empty,
    output logic [PAYLOAD_W-1:0] o_front_payload,
    output logic [PRIO_W-1:0]    o_front_level
);

    t_mem_req             mem_req;
    t_result              res;
    logic                 res_vld;
    logic [PAYLOAD_W-1:0] rd_data;

    assign busy = 1'b0;

    mlpq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (start && !busy),
        .i_op           (i_op),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_mem_req      (mem_req),
        .o_res_vld      (res_vld),
        .o_res          (res)
    );

    mlpq_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Front payload: zero when empty, forwarded item when just written
    always_comb begin
        o_done          = res_vld;
        o_accepted      = res.accepted;
        o_all_empty     = res.all_empty;
        o_front_level   = res.level;
        if (res.all_empty) begin
            o_front_payload = '0;
        end else if (res.bypass) begin
            o_front_payload = res.pay;
        end else begin
            o_front_payload = rd_data;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the strict-priority multilevel queue.
`timescale 1ns / 100ps

module testbench;
    import mlpq_pkg::*;

    // One queue operation waiting to be driven, with the idle cycles that follow it
    typedef struct {
        logic                 op;
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] pay;
        int                   gap_after;
    } queue_op_t;

    // Status reported after one operation
    typedef struct {
        logic                 accepted;
        logic                 all_empty;
        logic [PAYLOAD_W-1:0] front_payload;
        logic [PRIO_W-1:0]    front_level;
    } queue_status_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [PRIO_W-1:0]    i_cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_op = OP_ENQ;
    logic [PRIO_W-1:0]    i_priority_req = '0;
    logic [PAYLOAD_W-1:0] i_payload = '0;
    logic                 o_done;
    logic                 o_accepted;
    logic                 o_all_empty;
    logic [PAYLOAD_W-1:0] o_front_payload;
    logic [PRIO_W-1:0]    o_front_level;

    // Shadow copy of the queue contents and the level register
    logic [PAYLOAD_W-1:0] fifo_mem [MAX_LEVELS][LEVEL_DEPTH];
    int                   fifo_head [MAX_LEVELS];
    int                   fifo_tail [MAX_LEVELS];
    int                   fifo_count [MAX_LEVELS];
    logic [PRIO_W-1:0]    levels_reg;

    queue_op_t     pending_ops [$];
    queue_status_t expected_status [$];
    queue_op_t     drive_op;
    int            idle_left = 0;
    int            error_count = 0;

    // Level settings for the random phases; 0 and values above 8 are clamped
    int level_plan [12] = '{1, 3, 0, 8, 2, 12, 15, 5, 7, 4, 1, 8};

    multilevel_priority_fifo u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_priority_req  (i_priority_req),
        .i_payload       (i_payload),
        .o_done          (o_done),
        .o_accepted      (o_accepted),
        .o_all_empty     (o_all_empty),
        .o_front_payload (o_front_payload),
        .o_front_level   (o_front_level)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endfunction

    // Enabled level count after clamping to 1..MAX_LEVELS
    function automatic int active_levels();
        int n;
        n = levels_reg;
        if (n < 1) n = 1;
        if (n > MAX_LEVELS) n = MAX_LEVELS;
        return n;
    endfunction

    // Index of the highest-priority enabled level holding an item, -1 if none
    function automatic int front_index();
        for (int i = 0; i < active_levels(); i++) begin
            if (fifo_count[i] != 0) return i;
        end
        return -1;
    endfunction

    // Apply one operation to the shadow queue and record the status it gives
    function automatic void predict_queue_op(logic op, logic [PRIO_W-1:0] prio,
                                             logic [PAYLOAD_W-1:0] pay);
        queue_status_t st;
        int lvl;
        st.accepted = 1'b0;
        if (op == OP_ENQ) begin
            if (prio >= 1 && prio <= active_levels()) begin
                lvl = int'(prio) - 1;
                if (fifo_count[lvl] < LEVEL_DEPTH) begin
                    fifo_mem[lvl][fifo_tail[lvl]] = pay;
                    fifo_tail[lvl] = (fifo_tail[lvl] + 1) % LEVEL_DEPTH;
                    fifo_count[lvl]++;
                    st.accepted = 1'b1;
                end
            end
        end else begin
            lvl = front_index();
            if (lvl >= 0) begin
                fifo_head[lvl] = (fifo_head[lvl] + 1) % LEVEL_DEPTH;
                fifo_count[lvl]--;
                st.accepted = 1'b1;
            end
        end
        lvl = front_index();
        if (lvl < 0) begin
            st.all_empty     = 1'b1;
            st.front_payload = '0;
            st.front_level   = '0;
        end else begin
            st.all_empty     = 1'b0;
            st.front_payload = fifo_mem[lvl][fifo_head[lvl]];
            st.front_level   = PRIO_W'(lvl + 1);
        end
        expected_status.push_back(st);
    endfunction

    // Mostly random payloads, with the all-zero and all-one corners now and then
    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Queue one operation; quiet means no idle cycles after it
    function automatic void add_op(logic op, logic [PRIO_W-1:0] prio,
                                   logic [PAYLOAD_W-1:0] pay, bit quiet);
        queue_op_t item;
        item.op   = op;
        item.prio = prio;
        item.pay  = pay;
        item.gap_after = (quiet || $urandom_range(0, 5) != 0) ? 0 : $urandom_range(1, 4);
        pending_ops.push_back(item);
    endfunction

    // Random traffic in bursts: fill a level (often past full), drain (often
    // past empty), valid mixes, and noise with any priority value
    task automatic gen_phase(input int n_items, input bit quiet);
        int made, mode, len, lvl;
        bit burst_quiet;
        made = 0;
        while (made < n_items) begin
            mode = $urandom_range(0, 19);
            burst_quiet = quiet || ($urandom_range(0, 3) == 0);
            if (mode < 8) begin
                len = $urandom_range(6, 20);
                lvl = $urandom_range(1, active_levels());
                for (int k = 0; k < len; k++)
                    add_op(OP_ENQ, PRIO_W'(lvl), rand_payload(), burst_quiet);
            end else if (mode < 15) begin
                len = $urandom_range(4, 24);
                for (int k = 0; k < len; k++)
                    add_op(OP_DEQ, PRIO_W'($urandom_range(0, 15)), $urandom, burst_quiet);
            end else if (mode < 18) begin
                len = 8;
                for (int k = 0; k < len; k++)
                    add_op($urandom_range(0, 1) ? OP_DEQ : OP_ENQ,
                           PRIO_W'($urandom_range(1, active_levels())), rand_payload(),
                           burst_quiet);
            end else begin
                len = 6;
                for (int k = 0; k < len; k++)
                    add_op($urandom_range(0, 1) ? OP_DEQ : OP_ENQ,
                           PRIO_W'($urandom_range(0, 15)), rand_payload(), burst_quiet);
            end
            made += len;
        end
    endtask

    // Wait until every queued item is taken and every status has come back
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((pending_ops.size() != 0 || start || expected_status.size() != 0)
               && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Write the level register while the queue is idle
    task automatic write_levels(input logic [PRIO_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        levels_reg = value;
    endtask

    // Driver: predicts each accepted item, then presents the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                predict_queue_op(i_op, i_priority_req, i_payload);
            end
            if (!(start && busy)) begin
                if (idle_left != 0) begin
                    start     <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (pending_ops.size() != 0) begin
                    drive_op = pending_ops.pop_front();
                    i_op           <= drive_op.op;
                    i_priority_req <= drive_op.prio;
                    i_payload      <= drive_op.pay;
                    start          <= 1'b1;
                    idle_left      <= drive_op.gap_after;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_status.size() == 0) begin
                flag_error("result with no operation outstanding");
            end else begin
                queue_status_t st;
                st = expected_status.pop_front();
                if (o_accepted !== st.accepted || o_all_empty !== st.all_empty
                    || o_front_payload !== st.front_payload
                    || o_front_level !== st.front_level) begin
                    flag_error($sformatf(
                        "exp acc=%0b empty=%0b pay=%h lvl=%0d, got acc=%0b empty=%0b pay=%h lvl=%0d",
                        st.accepted, st.all_empty, st.front_payload, st.front_level,
                        o_accepted, o_all_empty, o_front_payload, o_front_level));
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            fifo_head[i]  = 0;
            fifo_tail[i]  = 0;
            fifo_count[i] = 0;
        end
        levels_reg = LEVELS_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, bad priorities, both payload corners,
        // priority order, then one level filled until an enqueue bounces
        add_op(OP_DEQ, 4'd0, '0, 1'b0);
        add_op(OP_ENQ, 4'd0, 32'h1, 1'b0);
        add_op(OP_ENQ, 4'd15, 32'h2, 1'b0);
        add_op(OP_ENQ, 4'd9, 32'h3, 1'b0);
        add_op(OP_ENQ, 4'd8, '1, 1'b0);
        add_op(OP_ENQ, 4'd1, '0, 1'b0);
        add_op(OP_DEQ, 4'd15, '1, 1'b0);
        for (int k = 0; k < LEVEL_DEPTH + 1; k++)
            add_op(OP_ENQ, 4'd3, (k % 2) ? 32'hA5A5_5A5A : ~32'hA5A5_5A5A ^ k, 1'b0);
        add_op(OP_DEQ, 4'd0, '0, 1'b0);

        // Random phases over several level settings; the tail runs with no gaps
        for (int p = 0; p < 12; p++) begin
            write_levels(PRIO_W'(level_plan[p]));
            gen_phase(135, p >= 10);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_status.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_status.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
